### rtl/uwt_pkg.sv
package uwt_pkg;

   localparam int CODE_BITS = 21;
   localparam int WORD_BITS = 16;
   localparam int CSR_CHARS = 4;

   localparam logic [2:0] CSR_EXTRA_COUNT = 3'd0;
   localparam logic [2:0] CSR_EXTRA_A     = 3'd1;
   localparam logic [2:0] CSR_EXTRA_D     = 3'd4;

   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;

   localparam logic [CODE_BITS-1:0] CP_ASCII_END  = 21'h000080;
   localparam logic [CODE_BITS-1:0] CP_LOWER_A    = 21'h000061;
   localparam logic [CODE_BITS-1:0] CP_LOWER_Z    = 21'h00007A;
   localparam logic [CODE_BITS-1:0] CP_UPPER_A    = 21'h000041;
   localparam logic [CODE_BITS-1:0] CP_UPPER_Z    = 21'h00005A;
   localparam logic [CODE_BITS-1:0] CP_DIGIT_0    = 21'h000030;
   localparam logic [CODE_BITS-1:0] CP_DIGIT_9    = 21'h000039;
   localparam logic [CODE_BITS-1:0] CP_APOS       = 21'h000027;
   localparam logic [CODE_BITS-1:0] CP_HYPHEN     = 21'h00002D;
   localparam logic [CODE_BITS-1:0] CP_RSQUOTE    = 21'h002019;
   localparam logic [CODE_BITS-1:0] CP_LATIN1_END = 21'h0000BF;
   localparam logic [CODE_BITS-1:0] CP_TIMES      = 21'h0000D7;
   localparam logic [CODE_BITS-1:0] CP_DIVIDE     = 21'h0000F7;
   localparam logic [CODE_BITS-1:0] CP_PUNCT_LO   = 21'h002000;
   localparam logic [CODE_BITS-1:0] CP_PUNCT_HI   = 21'h00206F;

   typedef enum logic [1:0] {
      KIND_LETTER,
      KIND_DIGIT,
      KIND_APOS,
      KIND_BREAK
   } kind_type;

   typedef struct packed {
      logic                 word_valid;
      logic [WORD_BITS-1:0] first_byte;
      logic [WORD_BITS-1:0] end_byte;
      logic [WORD_BITS-1:0] start_char;
      logic [WORD_BITS-1:0] char_length;
      logic                 text_done;
      logic                 run_last;
   } rsp_type;

   function automatic kind_type classify(input logic [CODE_BITS-1:0] code);
      kind_type k;
      if (code < CP_ASCII_END) begin
         if ((code >= CP_LOWER_A && code <= CP_LOWER_Z) ||
             (code >= CP_UPPER_A && code <= CP_UPPER_Z)) begin
            k = KIND_LETTER;
         end else if (code >= CP_DIGIT_0 && code <= CP_DIGIT_9) begin
            k = KIND_DIGIT;
         end else if (code == CP_APOS) begin
            k = KIND_APOS;
         end else begin
            k = KIND_BREAK;
         end
      end else if (code == CP_RSQUOTE) begin
         k = KIND_APOS;
      end else if (code <= CP_LATIN1_END) begin
         k = KIND_BREAK;
      end else if (code == CP_TIMES || code == CP_DIVIDE) begin
         k = KIND_BREAK;
      end else if (code >= CP_PUNCT_LO && code <= CP_PUNCT_HI) begin
         k = KIND_BREAK;
      end else begin
         k = KIND_LETTER;
      end
      return k;
   endfunction

endpackage

### rtl/uwt_csr.sv
module uwt_csr #(
   parameter int EXTRA_CHARS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [uwt_pkg::CODE_BITS-1:0] csr_data,
   input  logic [uwt_pkg::CODE_BITS-1:0] match_code,
   output logic                         code_is_extra
);
   import uwt_pkg::*;

   logic [2:0]           count_ff;
   logic [CODE_BITS-1:0] char_ff [CSR_CHARS];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < CSR_CHARS; i++) begin
            char_ff[i] <= '0;
         end
      end else if (csr_write) begin
         priority if (csr_index == CSR_EXTRA_COUNT) begin
            count_ff <= csr_data[2:0];
         end else if (csr_index >= CSR_EXTRA_A && csr_index <= CSR_EXTRA_D &&
                      int'(csr_index) <= EXTRA_CHARS) begin
            char_ff[2'(csr_index - CSR_EXTRA_A)] <= csr_data;
         end
      end
   end

   // entries past the writable ones stay zero
   always_comb begin
      code_is_extra = 1'b0;
      for (int i = 0; i < EXTRA_CHARS; i++) begin
         if (i < int'(count_ff)) begin
            if (i < CSR_CHARS) begin
               if (char_ff[2'(i)] == match_code) code_is_extra = 1'b1;
            end else if (match_code == '0) begin
               code_is_extra = 1'b1;
            end
         end
      end
      if (match_code == CP_HYPHEN) code_is_extra = 1'b0;
   end

endmodule

### rtl/uwt_core.sv
module uwt_core #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [7:0]                   text_byte,
   input  logic                         final_byte,
   output logic [uwt_pkg::CODE_BITS-1:0] char_code,
   input  logic                         code_is_extra,
   output logic [1:0]                   rsp_count,
   output uwt_pkg::rsp_type             rsp_first,
   output uwt_pkg::rsp_type             rsp_second
);
   import uwt_pkg::*;

   localparam int OB = OFFSET_BITS;

   function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a, input logic [2:0] n);
      logic [OB:0] s;
      s = {1'b0, a} + (OB+1)'(n);
      return s[OB] ? '1 : s[OB-1:0];
   endfunction

   logic [CODE_BITS-1:0] partial_ff, partial_in;
   logic [1:0]           expected_ff, expected_in;
   logic [1:0]           buffered_ff, buffered_in;
   logic [OB-1:0]        byte_pos_ff, byte_pos_in;
   logic [OB-1:0]        char_pos_ff, char_pos_in;
   logic                 in_word_ff, in_word_in;
   logic                 has_digit_ff, has_digit_in;
   logic [OB-1:0]        start_byte_ff, start_byte_in;
   logic [OB-1:0]        start_char_ff, start_char_in;
   logic [OB-1:0]        core_byte_ff, core_byte_in;
   logic [OB-1:0]        core_char_ff, core_char_in;

   logic                 is_cont, pending, drop;
   logic [1:0]           drop_n;
   logic [CODE_BITS-1:0] cont_code, seq_partial;
   logic [1:0]           seq_expected, seq_buffered;
   logic                 char_take, char_valid;
   logic [2:0]           char_len;
   kind_type             kind;
   logic [OB-1:0]        pos_a, cpos_a;
   logic                 in_word_a, digit_a;
   logic [OB-1:0]        pos_b, cpos_b, start_b, cstart_b, core_b, ccore_b;
   logic                 in_word_b, digit_b;
   logic                 word_one, word_two;
   logic [OB-1:0]        len_one, len_two;
   rsp_type              rec_one, rec_two, rec_empty;

   // utf-8 sequence tracking
   always_comb begin
      is_cont      = (text_byte & CONT_MASK) == CONT_TAG;
      pending      = expected_ff != 2'd0;
      drop         = pending && !is_cont;
      drop_n       = drop ? buffered_ff : 2'd0;
      cont_code    = {partial_ff[CODE_BITS-7:0], text_byte[5:0]};
      seq_partial  = '0;
      seq_expected = 2'd0;
      seq_buffered = 2'd0;
      char_take    = 1'b0;
      char_valid   = 1'b0;
      char_len     = 3'd1;
      char_code    = {{(CODE_BITS-8){1'b0}}, text_byte};
      if (pending && is_cont) begin
         if (expected_ff == 2'd1) begin
            char_take  = 1'b1;
            char_valid = 1'b1;
            char_len   = {1'b0, buffered_ff} + 3'd1;
            char_code  = cont_code;
         end else begin
            seq_partial  = cont_code;
            seq_expected = expected_ff - 2'd1;
            seq_buffered = buffered_ff + 2'd1;
         end
      end else begin
         priority if (!text_byte[7]) begin
            char_take  = 1'b1;
            char_valid = 1'b1;
         end else if (text_byte >= LEAD_FOUR) begin
            seq_partial  = {{(CODE_BITS-3){1'b0}}, text_byte[2:0]};
            seq_expected = 2'd3;
            seq_buffered = 2'd1;
         end else if (text_byte >= LEAD_THREE) begin
            seq_partial  = {{(CODE_BITS-4){1'b0}}, text_byte[3:0]};
            seq_expected = 2'd2;
            seq_buffered = 2'd1;
         end else if (text_byte >= LEAD_TWO) begin
            seq_partial  = {{(CODE_BITS-5){1'b0}}, text_byte[4:0]};
            seq_expected = 2'd1;
            seq_buffered = 2'd1;
         end else begin
            char_take = 1'b1;
         end
      end
   end

   always_comb begin
      if (!char_valid) begin
         kind = KIND_BREAK;
      end else begin
         kind = classify(char_code);
         if (kind == KIND_BREAK && code_is_extra) kind = KIND_APOS;
      end
   end

   // word tracking: dropped bytes first, then the decoded character
   always_comb begin
      pos_a     = sat_add(byte_pos_ff, {1'b0, drop_n});
      cpos_a    = sat_add(char_pos_ff, {1'b0, drop_n});
      in_word_a = in_word_ff && !drop;
      digit_a   = has_digit_ff && !drop;
      word_one  = (drop || (char_take && kind == KIND_BREAK)) && in_word_ff &&
                  !has_digit_ff && (core_byte_ff > start_byte_ff);

      in_word_b = in_word_a;
      digit_b   = digit_a;
      start_b   = start_byte_ff;
      cstart_b  = start_char_ff;
      core_b    = core_byte_ff;
      ccore_b   = core_char_ff;
      pos_b     = pos_a;
      cpos_b    = cpos_a;
      if (char_take) begin
         pos_b  = sat_add(pos_a, char_len);
         cpos_b = sat_add(cpos_a, 3'd1);
         unique case (kind)
            KIND_BREAK: begin
               in_word_b = 1'b0;
               digit_b   = 1'b0;
            end
            KIND_LETTER, KIND_DIGIT: begin
               if (!in_word_a) begin
                  start_b  = pos_a;
                  cstart_b = cpos_a;
               end
               in_word_b = 1'b1;
               if (kind == KIND_DIGIT) digit_b = 1'b1;
               core_b  = sat_add(pos_a, char_len);
               ccore_b = sat_add(cpos_a, 3'd1);
            end
            default: begin
            end
         endcase
      end
      word_two = final_byte && in_word_b && !digit_b && (core_b > start_b);
   end

   always_comb begin
      if (final_byte) begin
         partial_in    = '0;
         expected_in   = 2'd0;
         buffered_in   = 2'd0;
         byte_pos_in   = '0;
         char_pos_in   = '0;
         in_word_in    = 1'b0;
         has_digit_in  = 1'b0;
         start_byte_in = '0;
         start_char_in = '0;
         core_byte_in  = '0;
         core_char_in  = '0;
      end else begin
         partial_in    = seq_partial;
         expected_in   = seq_expected;
         buffered_in   = seq_buffered;
         byte_pos_in   = pos_b;
         char_pos_in   = cpos_b;
         in_word_in    = in_word_b;
         has_digit_in  = digit_b;
         start_byte_in = start_b;
         start_char_in = cstart_b;
         core_byte_in  = core_b;
         core_char_in  = ccore_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         expected_ff   <= 2'd0;
         buffered_ff   <= 2'd0;
         byte_pos_ff   <= '0;
         char_pos_ff   <= '0;
         in_word_ff    <= 1'b0;
         has_digit_ff  <= 1'b0;
         start_byte_ff <= '0;
         start_char_ff <= '0;
         core_byte_ff  <= '0;
         core_char_ff  <= '0;
      end else if (fire) begin
         partial_ff    <= partial_in;
         expected_ff   <= expected_in;
         buffered_ff   <= buffered_in;
         byte_pos_ff   <= byte_pos_in;
         char_pos_ff   <= char_pos_in;
         in_word_ff    <= in_word_in;
         has_digit_ff  <= has_digit_in;
         start_byte_ff <= start_byte_in;
         start_char_ff <= start_char_in;
         core_byte_ff  <= core_byte_in;
         core_char_ff  <= core_char_in;
      end
   end

   // result records
   always_comb begin
      len_one = core_char_ff - start_char_ff;
      len_two = ccore_b - cstart_b;

      rec_one.word_valid  = 1'b1;
      rec_one.first_byte  = WORD_BITS'(start_byte_ff);
      rec_one.end_byte    = WORD_BITS'(core_byte_ff);
      rec_one.start_char  = WORD_BITS'(start_char_ff);
      rec_one.char_length = WORD_BITS'(len_one);
      rec_one.text_done   = 1'b0;
      rec_one.run_last    = 1'b0;

      rec_two.word_valid  = 1'b1;
      rec_two.first_byte  = WORD_BITS'(start_b);
      rec_two.end_byte    = WORD_BITS'(core_b);
      rec_two.start_char  = WORD_BITS'(cstart_b);
      rec_two.char_length = WORD_BITS'(len_two);
      rec_two.text_done   = 1'b1;
      rec_two.run_last    = 1'b1;

      rec_empty           = '0;
      rec_empty.text_done = 1'b1;
      rec_empty.run_last  = 1'b1;

      rsp_first  = rec_empty;
      rsp_second = rec_two;
      rsp_count  = 2'd0;
      unique case ({word_one, word_two})
         2'b11: begin
            rsp_first  = rec_one;
            rsp_second = rec_two;
            rsp_count  = 2'd2;
         end
         2'b10: begin
            rsp_first           = rec_one;
            rsp_first.run_last  = 1'b1;
            rsp_first.text_done = final_byte;
            rsp_count           = 2'd1;
         end
         2'b01: begin
            rsp_first = rec_two;
            rsp_count = 2'd1;
         end
         default: begin
            rsp_first = rec_empty;
            rsp_count = final_byte ? 2'd1 : 2'd0;
         end
      endcase
   end

endmodule

### rtl/uwt_rsp_queue.sv
module uwt_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  uwt_pkg::rsp_type push_first,
   input  uwt_pkg::rsp_type push_second,
   input  logic             pop,
   output logic [1:0]       space,
   output logic             head_valid,
   output uwt_pkg::rsp_type head
);
   import uwt_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    entry_ff [2];
   rsp_type    entry_in [2];
   logic [1:0] remain;

   assign head_valid = count_ff != 2'd0;
   assign head       = entry_ff[0];
   assign space      = 2'd2 - count_ff + {1'b0, pop};

   always_comb begin
      remain      = count_ff - {1'b0, pop};
      entry_in[0] = pop ? entry_ff[1] : entry_ff[0];
      entry_in[1] = entry_ff[1];
      if (push_count != 2'd0) begin
         if (remain == 2'd0) begin
            entry_in[0] = push_first;
            entry_in[1] = push_second;
         end else begin
            entry_in[1] = push_first;
         end
      end
      count_in = remain + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

endmodule

### rtl/utf8_word_tokenizer.sv
// path: a taken request is held in the input register, and its results are written into the queue
// throughput: one byte per cycle while the queue has room; results drain one per cycle through a
//    two-entry queue, so a byte that closes two words holds the input until the queue has room
//    for both, and longer while the receiver stalls
// reset: synchronous, active high; clears decode and word state and the extra character
//    registers to zero, and empties the input register and the queue
module utf8_word_tokenizer #(
   parameter int EXTRA_CHARS = 4,
   parameter int OFFSET_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_text_byte,
   input  logic                         req_final_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_word_valid,
   output logic [uwt_pkg::WORD_BITS-1:0] rsp_start_byte,
   output logic [uwt_pkg::WORD_BITS-1:0] rsp_end_byte,
   output logic [uwt_pkg::WORD_BITS-1:0] rsp_start_char,
   output logic [uwt_pkg::WORD_BITS-1:0] rsp_char_length,
   output logic                         rsp_text_done,
   output logic                         rsp_run_last,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [uwt_pkg::CODE_BITS-1:0] csr_data
);
   import uwt_pkg::*;

   logic                 in_valid_ff;
   logic [7:0]           byte_ff;
   logic                 final_ff;
   logic                 fire;
   logic                 pop;
   logic [1:0]           space;
   logic [1:0]           rsp_count;
   logic [CODE_BITS-1:0] char_code;
   logic                 code_is_extra;
   rsp_type              rsp_first, rsp_second, head;

   assign pop       = rsp_valid && rsp_ready;
   assign fire      = in_valid_ff && (rsp_count <= space);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff  <= req_text_byte;
         final_ff <= req_final_byte;
      end
   end

   uwt_csr #(
      .EXTRA_CHARS(EXTRA_CHARS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .match_code    (char_code),
      .code_is_extra (code_is_extra)
   );

   uwt_core #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .text_byte     (byte_ff),
      .final_byte    (final_ff),
      .char_code     (char_code),
      .code_is_extra (code_is_extra),
      .rsp_count     (rsp_count),
      .rsp_first     (rsp_first),
      .rsp_second    (rsp_second)
   );

   uwt_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (fire ? rsp_count : 2'd0),
      .push_first  (rsp_first),
      .push_second (rsp_second),
      .pop         (pop),
      .space       (space),
      .head_valid  (rsp_valid),
      .head        (head)
   );

   assign rsp_word_valid  = head.word_valid;
   assign rsp_start_byte  = head.first_byte;
   assign rsp_end_byte    = head.end_byte;
   assign rsp_start_char  = head.start_char;
   assign rsp_char_length = head.char_length;
   assign rsp_text_done   = head.text_done;
   assign rsp_run_last    = head.run_last;

endmodule
